// File: hdl/ale_pkg.sv
// Shared types, codes and defaults for the array list engine.
package ale_pkg;

	localparam int CAPACITY_DEF = 128;

	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_APPEND = 3'd1;
	localparam logic [2:0] OP_GET    = 3'd2;
	localparam logic [2:0] OP_LOCATE = 3'd3;
	localparam logic [2:0] OP_INSERT = 3'd4;
	localparam logic [2:0] OP_DELETE = 3'd5;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BADPOS   = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [2:0]         opcode;
		logic [7:0]         position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] read_value;
		logic [6:0]         found_position;
		logic [7:0]         count_now;
	} rsp_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_CLEAR,
		DP_APPEND,
		DP_GET_RD,
		DP_GET_CAP,
		DP_LOC_INIT,
		DP_LOC_STEP,
		DP_FOUND,
		DP_UP_INIT,
		DP_UP_STEP,
		DP_PUT,
		DP_DN_INIT,
		DP_DN_STEP,
		DP_DEC,
		DP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] status;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic       full;
		logic       pos_ge_cnt;
		logic       pos_gt_cnt;
		logic       idx_lt_cnt;
		logic       idx_gt_pos;
		logic       pend;
		logic       match;
	} dp_sts_t;

endpackage

// File: hdl/ale_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ale_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/ale_dp.sv
// Datapath of the array list engine: store, count, walk pointers and result register.
module ale_dp import ale_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  req_t    req,
	input  dp_cmd_t cmd,
	output dp_sts_t sts,
	output logic    done,
	output rsp_t    rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > 8) ? CW : 8;

	req_t          req_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [AW-1:0] widx_q;
	logic          pend_q;
	logic [31:0]   rd_q;
	logic [AW-1:0] found_q;
	rsp_t          rsp_q;
	logic          done_q;

	logic          we;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;
	logic          re;
	logic [AW-1:0] raddr;
	logic [31:0]   rdata;

	logic [XW-1:0] cnt_x;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] idx_x;
	logic [XW-1:0] fnd_x;
	logic [XW-1:0] pos_inc;
	logic [CW-1:0] idx_dec;

	assign cnt_x   = XW'(count_q);
	assign pos_x   = XW'(req_q.position);
	assign idx_x   = XW'(idx_q);
	assign fnd_x   = XW'(found_q);
	assign pos_inc = pos_x + XW'(1);
	assign idx_dec = idx_q - CW'(1);

	assign sts.opcode     = req_q.opcode;
	assign sts.full       = (count_q == CW'(CAPACITY));
	assign sts.pos_ge_cnt = (pos_x >= cnt_x);
	assign sts.pos_gt_cnt = (pos_x > cnt_x);
	assign sts.idx_lt_cnt = (idx_q < count_q);
	assign sts.idx_gt_pos = (idx_x > pos_x);
	assign sts.pend       = pend_q;
	assign sts.match      = pend_q && (rdata == req_q.value);

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = rdata;
		re    = 1'b0;
		raddr = '0;
		case (cmd.op)
			DP_APPEND: begin
				we    = 1'b1;
				waddr = count_q[AW-1:0];
				wdata = req_q.value;
			end
			DP_GET_RD: begin
				re    = 1'b1;
				raddr = pos_x[AW-1:0];
			end
			DP_LOC_STEP: begin
				re    = sts.idx_lt_cnt;
				raddr = idx_q[AW-1:0];
			end
			DP_UP_STEP: begin
				re    = sts.idx_gt_pos;
				raddr = idx_dec[AW-1:0];
				we    = pend_q;
				waddr = widx_q;
			end
			DP_PUT: begin
				we    = 1'b1;
				waddr = pos_x[AW-1:0];
				wdata = req_q.value;
			end
			DP_DN_STEP: begin
				re    = sts.idx_lt_cnt;
				raddr = idx_q[AW-1:0];
				we    = pend_q;
				waddr = widx_q;
			end
			default: begin
			end
		endcase
	end

	ale_ram #(
		.WIDTH(32),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (cmd.op)
				DP_LOAD: begin
					req_q   <= req;
					rd_q    <= '0;
					found_q <= '0;
				end
				DP_CLEAR: begin
					count_q <= '0;
				end
				DP_APPEND, DP_PUT: begin
					count_q <= count_q + CW'(1);
				end
				DP_GET_CAP: begin
					rd_q <= rdata;
				end
				DP_LOC_INIT: begin
					idx_q  <= '0;
					pend_q <= 1'b0;
				end
				DP_LOC_STEP: begin
					pend_q <= sts.idx_lt_cnt;
					if (sts.idx_lt_cnt) begin
						widx_q <= idx_q[AW-1:0];
						idx_q  <= idx_q + CW'(1);
					end
				end
				DP_FOUND: begin
					found_q <= widx_q;
				end
				DP_UP_INIT: begin
					idx_q  <= count_q;
					pend_q <= 1'b0;
				end
				DP_UP_STEP: begin
					pend_q <= sts.idx_gt_pos;
					if (sts.idx_gt_pos) begin
						widx_q <= idx_q[AW-1:0];
						idx_q  <= idx_dec;
					end
				end
				DP_DN_INIT: begin
					idx_q  <= pos_inc[CW-1:0];
					pend_q <= 1'b0;
				end
				DP_DN_STEP: begin
					pend_q <= sts.idx_lt_cnt;
					if (sts.idx_lt_cnt) begin
						widx_q <= idx_dec[AW-1:0];
						idx_q  <= idx_q + CW'(1);
					end
				end
				DP_DEC: begin
					count_q <= count_q - CW'(1);
				end
				DP_EMIT: begin
					rsp_q.status         <= cmd.status;
					rsp_q.read_value     <= rd_q;
					rsp_q.found_position <= fnd_x[6:0];
					rsp_q.count_now      <= cnt_x[7:0];
					done_q               <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("element count above capacity");

	a_done_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(cmd.op == DP_EMIT))
		else $error("result beat without emit command");

	a_no_grow_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == DP_APPEND || cmd.op == DP_PUT) |-> !sts.full)
		else $error("store grown while full");

endmodule

// File: hdl/ale_ctrl.sv
// Controller state machine of the array list engine.
module ale_ctrl import ale_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  dp_sts_t sts,
	output logic    busy,
	output dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_GET,
		S_LOC,
		S_UP,
		S_DN,
		S_FIN
	} state_t;

	state_t     state_q;
	state_t     state_d;
	logic [1:0] st_q;
	logic [1:0] st_d;
	logic       busy_q;

	always_comb begin
		state_d    = state_q;
		st_d       = st_q;
		cmd.op     = DP_NOP;
		cmd.status = st_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op  = DP_LOAD;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				st_d    = ST_OK;
				state_d = S_FIN;
				case (sts.opcode)
					OP_CLEAR: begin
						cmd.op = DP_CLEAR;
					end
					OP_APPEND: begin
						if (sts.full) begin
							st_d = ST_FULL;
						end else begin
							cmd.op = DP_APPEND;
						end
					end
					OP_GET: begin
						if (sts.pos_ge_cnt) begin
							st_d = ST_BADPOS;
						end else begin
							cmd.op  = DP_GET_RD;
							state_d = S_GET;
						end
					end
					OP_LOCATE: begin
						cmd.op  = DP_LOC_INIT;
						state_d = S_LOC;
					end
					OP_INSERT: begin
						if (sts.pos_gt_cnt) begin
							st_d = ST_BADPOS;
						end else if (sts.full) begin
							st_d = ST_FULL;
						end else begin
							cmd.op  = DP_UP_INIT;
							state_d = S_UP;
						end
					end
					OP_DELETE: begin
						if (sts.pos_ge_cnt) begin
							st_d = ST_BADPOS;
						end else begin
							cmd.op  = DP_DN_INIT;
							state_d = S_DN;
						end
					end
					default: begin
					end
				endcase
			end
			S_GET: begin
				cmd.op  = DP_GET_CAP;
				state_d = S_FIN;
			end
			S_LOC: begin
				if (sts.match) begin
					cmd.op  = DP_FOUND;
					st_d    = ST_OK;
					state_d = S_FIN;
				end else if (!sts.pend && !sts.idx_lt_cnt) begin
					st_d    = ST_NOTFOUND;
					state_d = S_FIN;
				end else begin
					cmd.op = DP_LOC_STEP;
				end
			end
			S_UP: begin
				if (!sts.pend && !sts.idx_gt_pos) begin
					cmd.op  = DP_PUT;
					state_d = S_FIN;
				end else begin
					cmd.op = DP_UP_STEP;
				end
			end
			S_DN: begin
				if (!sts.pend && !sts.idx_lt_cnt) begin
					cmd.op  = DP_DEC;
					state_d = S_FIN;
				end else begin
					cmd.op = DP_DN_STEP;
				end
			end
			S_FIN: begin
				cmd.op  = DP_EMIT;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= ST_OK;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			busy_q  <= (state_d != S_IDLE);
		end
	end

	assign busy = busy_q;

	a_busy_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (state_q != S_IDLE))
		else $error("busy out of step with state");

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy_q) |=> (state_q == S_EXEC))
		else $error("accepted beat not executed");

	a_fin_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |=> (state_q == S_IDLE))
		else $error("finish state not followed by idle");

endmodule

// File: hdl/array_list_engine_core.sv
// Array list engine: bounded list of signed words with clear, append, get, locate, insert, delete.
// Clear, append, unused opcodes and rejected beats finish without a store walk; get reads
//   one entry, locate walks the store until a match or the end of the list, and insert and
//   delete shift the elements between the position and the end of the list by one place.
// Throughput: one beat at a time, the store walk runs one entry per cycle on the single
//   RAM read and write port; busy is low again in the strobe cycle. The receiver cannot stall.
// Reset clears the element count and control state; store contents are kept as they are.
module array_list_engine_core import ale_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	ale_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.busy  (busy),
		.cmd   (cmd)
	);

	ale_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.sts   (sts),
		.done  (done),
		.rsp   (rsp)
	);

endmodule
